// ===== hw/rtl/cle_pkg.sv =====
`timescale 1ns / 1ps

package cle_pkg;

    typedef logic [7:0] char_t;

    localparam int LINE_LENGTH   = 32;
    localparam int KEYWORD_SLOTS = 16;

    localparam int POS_W        = $clog2(LINE_LENGTH);
    localparam int ARG_W        = 5;
    localparam int SCAN_W_RAW   = $clog2(LINE_LENGTH + KEYWORD_SLOTS);
    localparam int SCAN_W       = (SCAN_W_RAW > ARG_W) ? SCAN_W_RAW : ARG_W;
    localparam int SLOT_W       = $clog2(KEYWORD_SLOTS);
    localparam int KW_COUNT     = 10;
    localparam int KW_IDX_W     = 4;
    localparam int KW_TEXT_LEN  = 16;
    localparam int ACT_W        = 3;

    localparam char_t CH_ESC     = 8'h1B;
    localparam char_t CH_BRACKET = 8'h5B;
    localparam char_t CH_LF      = 8'h0A;
    localparam char_t CH_CR      = 8'h0D;
    localparam char_t CH_BS      = 8'h08;
    localparam char_t CH_SPACE   = 8'h20;
    localparam char_t CH_NUL     = 8'h00;

    localparam logic [ACT_W-1:0] ACT_IGNORE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ECHO   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ERASE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FOUND  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_MISS   = 3'd4;

    localparam logic [8*KW_TEXT_LEN-1:0] KW_STR [KW_COUNT] = '{
        (8*KW_TEXT_LEN)'("rst"),
        (8*KW_TEXT_LEN)'("ls"),
        (8*KW_TEXT_LEN)'("send"),
        (8*KW_TEXT_LEN)'("pgm"),
        (8*KW_TEXT_LEN)'("trinfo"),
        (8*KW_TEXT_LEN)'("trrst"),
        (8*KW_TEXT_LEN)'("trpgmmode"),
        (8*KW_TEXT_LEN)'("trpwroff"),
        (8*KW_TEXT_LEN)'("trpwron"),
        (8*KW_TEXT_LEN)'("stat")
    };

    localparam int KW_LEN [KW_COUNT] = '{3, 2, 4, 3, 6, 5, 9, 8, 7, 4};

    localparam char_t KW_PARAM [KW_COUNT] = '{
        8'h48, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd2, 8'd3, 8'd0
    };

    function automatic char_t kw_char(input logic [KW_IDX_W-1:0] k,
                                      input logic [SLOT_W-1:0] y);
        int len;
        int yi;
        char_t c;
        c  = CH_NUL;
        yi = int'(y);
        if (int'(k) < KW_COUNT) begin
            len = KW_LEN[k];
            if (yi < len) begin
                c = KW_STR[k][8*(len-1-yi) +: 8];
            end
        end
        return c;
    endfunction

    function automatic char_t kw_param(input logic [KW_IDX_W-1:0] k);
        char_t p;
        p = 8'd0;
        if (int'(k) < KW_COUNT) begin
            p = KW_PARAM[k];
        end
        return p;
    endfunction

    function automatic char_t reset_char(input logic [POS_W-1:0] a);
        char_t c;
        c = CH_NUL;
        if (int'(a) == 0) begin
            c = 8'h72;
        end else if (int'(a) == 1) begin
            c = 8'h73;
        end else if (int'(a) == 2) begin
            c = 8'h74;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/console_line_editor_command_matcher.sv =====
`timescale 1ns / 1ps

// Console line editor and command matcher. Each request carries one received
// byte; each byte yields exactly one result. Escape sequences and LF are
// ignored, other bytes are stored in a 32-entry line memory (at most 31 per
// line) and echoed, backspace erases, and CR matches the first word of the
// line (after leading spaces) against the ten built-in keywords. An ordinary
// byte is captured, then edited and written to the line memory once the
// output is free. For CR the line memory has a registered read port: each
// character is read in one state and compared in the next. A new byte is
// captured while the previous result still waits on the output.
module console_line_editor_command_matcher
    import cle_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rx_valid,
    output logic                 rx_stall,
    input  logic [7:0]           rx_char,
    output logic                 cmd_valid,
    input  logic                 cmd_stall,
    output logic [ACT_W-1:0]     action,
    output logic [7:0]           echo_char,
    output logic [KW_IDX_W-1:0]  command_index,
    output logic [7:0]           command_param,
    output logic [ARG_W-1:0]     arg_start,
    output logic                 repeated_line
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_PROC    = 3'd1;
    localparam logic [2:0] S_SKIP_RD = 3'd2;
    localparam logic [2:0] S_SKIP_EV = 3'd3;
    localparam logic [2:0] S_CMP_RD  = 3'd4;
    localparam logic [2:0] S_CMP_EV  = 3'd5;
    localparam logic [2:0] S_FIN     = 3'd6;

    logic [2:0]            state_reg, state_next;
    char_t                 char_reg, char_next;
    logic [POS_W-1:0]      wpos_reg, wpos_next;
    logic                  fresh_reg, fresh_next;
    logic                  esc_reg, esc_next;
    logic                  escb_reg, escb_next;
    logic [SCAN_W-1:0]     x_reg, x_next;
    logic [POS_W-1:0]      start_reg, start_next;
    logic [KW_IDX_W-1:0]   k_reg, k_next;
    logic [SLOT_W-1:0]     y_reg, y_next;
    logic                  oob_reg, oob_next;
    logic                  found_reg, found_next;
    logic                  rep_reg, rep_next;
    logic [ARG_W-1:0]      end_reg, end_next;

    logic                  out_valid_reg, out_valid_next;
    logic [ACT_W-1:0]      act_reg, act_next;
    char_t                 echo_reg, echo_next;
    logic [KW_IDX_W-1:0]   idx_reg, idx_next;
    char_t                 param_reg, param_next;
    logic [ARG_W-1:0]      arg_reg, arg_next;
    logic                  repo_reg, repo_next;

    char_t                 line_mem [LINE_LENGTH];
    logic [LINE_LENGTH-1:0] entry_vld_reg;
    char_t                 rd_data_reg;
    logic                  rd_vld_reg;
    logic [POS_W-1:0]      rd_addr_reg;

    logic                  mem_we;
    logic [POS_W-1:0]      mem_waddr;
    char_t                 mem_wdata;
    logic                  mem_re;
    logic [POS_W-1:0]      mem_raddr;

    logic                  out_free;
    char_t                 cur_char;
    char_t                 kc;
    logic [POS_W-1:0]      wp;

    assign rx_stall      = (state_reg != S_IDLE);
    assign cmd_valid     = out_valid_reg;
    assign action        = act_reg;
    assign echo_char     = echo_reg;
    assign command_index = idx_reg;
    assign command_param = param_reg;
    assign arg_start     = arg_reg;
    assign repeated_line = repo_reg;

    assign out_free  = !out_valid_reg || !cmd_stall;
    assign mem_raddr = x_reg[POS_W-1:0];
    assign cur_char  = rd_vld_reg ? rd_data_reg : reset_char(rd_addr_reg);
    assign kc        = kw_char(k_reg, y_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= line_mem[mem_raddr];
            rd_addr_reg <= mem_raddr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_vld_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                entry_vld_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re)
            begin
                rd_vld_reg <= entry_vld_reg[mem_raddr];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        char_next      = char_reg;
        wpos_next      = wpos_reg;
        fresh_next     = fresh_reg;
        esc_next       = esc_reg;
        escb_next      = escb_reg;
        x_next         = x_reg;
        start_next     = start_reg;
        k_next         = k_reg;
        y_next         = y_reg;
        oob_next       = oob_reg;
        found_next     = found_reg;
        rep_next       = rep_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg && cmd_stall;
        act_next       = act_reg;
        echo_next      = echo_reg;
        idx_next       = idx_reg;
        param_next     = param_reg;
        arg_next       = arg_reg;
        repo_next      = repo_reg;
        mem_we         = 1'b0;
        mem_waddr      = wpos_reg;
        mem_wdata      = CH_NUL;
        mem_re         = 1'b0;
        wp             = fresh_reg ? '0 : wpos_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (rx_valid)
                begin
                    char_next  = rx_char;
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                if (!escb_reg && !(esc_reg && char_reg == CH_BRACKET) &&
                    char_reg != CH_ESC && char_reg != CH_LF && char_reg == CH_CR)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = wpos_reg;
                    mem_wdata  = CH_NUL;
                    esc_next   = 1'b0;
                    rep_next   = fresh_reg;
                    fresh_next = 1'b1;
                    x_next     = '0;
                    state_next = S_SKIP_RD;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    act_next       = ACT_IGNORE;
                    echo_next      = CH_NUL;
                    idx_next       = '0;
                    param_next     = '0;
                    arg_next       = '0;
                    repo_next      = 1'b0;
                    state_next     = S_IDLE;
                    priority if (escb_reg)
                    begin
                        esc_next  = 1'b0;
                        escb_next = 1'b0;
                    end
                    else if (esc_reg && char_reg == CH_BRACKET)
                    begin
                        escb_next = 1'b1;
                    end
                    else if (char_reg == CH_ESC)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (char_reg == CH_LF)
                    begin
                        esc_next = esc_reg;
                    end
                    else
                    begin
                        esc_next   = 1'b0;
                        fresh_next = 1'b0;
                        wpos_next  = wp;
                        if (char_reg == CH_BS)
                        begin
                            if (wp != '0)
                            begin
                                wpos_next = wp - 1'b1;
                                act_next  = ACT_ERASE;
                            end
                        end
                        else if (int'(wp) < LINE_LENGTH - 1)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = wp;
                            mem_wdata = char_reg;
                            wpos_next = wp + 1'b1;
                            act_next  = ACT_ECHO;
                            echo_next = char_reg;
                        end
                    end
                end
            end
            S_SKIP_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_SKIP_EV;
            end
            S_SKIP_EV:
            begin
                if (cur_char == CH_SPACE)
                begin
                    if (x_reg == SCAN_W'(LINE_LENGTH - 1))
                    begin
                        found_next = 1'b0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        x_next     = x_reg + 1'b1;
                        state_next = S_SKIP_RD;
                    end
                end
                else
                begin
                    start_next = x_reg[POS_W-1:0];
                    k_next     = '0;
                    y_next     = '0;
                    state_next = S_CMP_RD;
                end
            end
            S_CMP_RD:
            begin
                oob_next   = (x_reg >= SCAN_W'(LINE_LENGTH));
                mem_re     = (x_reg < SCAN_W'(LINE_LENGTH));
                state_next = S_CMP_EV;
            end
            S_CMP_EV:
            begin
                if (kc == CH_NUL &&
                    (oob_reg || cur_char == CH_SPACE || cur_char == CH_NUL))
                begin
                    found_next = 1'b1;
                    end_next   = x_reg[ARG_W-1:0];
                    state_next = S_FIN;
                end
                else if ((!oob_reg && cur_char != kc) || (oob_reg && kc != CH_NUL) ||
                         y_reg == SLOT_W'(KEYWORD_SLOTS - 1))
                begin
                    if (k_reg == KW_IDX_W'(KW_COUNT - 1))
                    begin
                        found_next = 1'b0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        y_next     = '0;
                        x_next     = SCAN_W'(start_reg);
                        state_next = S_CMP_RD;
                    end
                end
                else
                begin
                    x_next     = x_reg + 1'b1;
                    y_next     = y_reg + 1'b1;
                    state_next = S_CMP_RD;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    echo_next      = CH_NUL;
                    repo_next      = rep_reg;
                    if (found_reg)
                    begin
                        act_next   = ACT_FOUND;
                        idx_next   = k_reg;
                        param_next = kw_param(k_reg);
                        arg_next   = end_reg;
                    end
                    else
                    begin
                        act_next   = ACT_MISS;
                        idx_next   = '0;
                        param_next = '0;
                        arg_next   = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wpos_reg      <= POS_W'(LINE_LENGTH - 1);
            fresh_reg     <= 1'b1;
            esc_reg       <= 1'b0;
            escb_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wpos_reg      <= wpos_next;
            fresh_reg     <= fresh_next;
            esc_reg       <= esc_next;
            escb_reg      <= escb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        x_reg     <= x_next;
        start_reg <= start_next;
        k_reg     <= k_next;
        y_reg     <= y_next;
        oob_reg   <= oob_next;
        found_reg <= found_next;
        rep_reg   <= rep_next;
        end_reg   <= end_next;
        act_reg   <= act_next;
        echo_reg  <= echo_next;
        idx_reg   <= idx_next;
        param_reg <= param_next;
        arg_reg   <= arg_next;
        repo_reg  <= repo_next;
    end

endmodule
